@@ src/thermal_plant_emulator_assert.svh @@
// assertion macros for the thermal plant emulator
`ifndef THERMAL_PLANT_EMULATOR_ASSERT_SVH
`define THERMAL_PLANT_EMULATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define TPE_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("thermal plant emulator assertion failed");
`define TPE_ASSERT(lbl, prop) `TPE_ASSERT_CLK(lbl, clk_i, rst_ni, prop)
`else
`define TPE_ASSERT_CLK(lbl, clk, rstn, prop)
`define TPE_ASSERT(lbl, prop)
`endif

`endif

@@ src/tpe_pkg.sv @@
// shared types, constants and helpers of the thermal plant emulator
package tpe_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_ENV_TEMP    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DELAY_LEN   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SIGNAL_GAIN = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_COOL_COEF   = 2'd3;

  localparam logic [31:0] ENV_TEMP_RST    = 32'd1572864;
  localparam logic [6:0]  DELAY_LEN_RST   = 7'd10;
  localparam logic [15:0] SIGNAL_GAIN_RST = 16'd6554;
  localparam logic [15:0] COOL_COEF_RST   = 16'd6554;

  // 0.003 in q0.24
  localparam logic [15:0] LAG_GAIN = 16'd50332;

  typedef struct packed {
    logic signed [31:0] env_temp;
    logic [6:0]         delay_len;
    logic [15:0]        signal_gain;
    logic [15:0]        cool_coef;
  } tpe_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

@@ src/tpe_if.sv @@
// valid/ready channel interfaces for drive input and result output
interface tpe_drive_if;
  logic        valid;
  logic        ready;
  logic [15:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink (input valid, input drive, output ready);
endinterface

interface tpe_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature;
  logic signed [31:0] heat_rate;

  modport source (output valid, output temperature, output heat_rate, input ready);
  modport sink (input valid, input temperature, input heat_rate, output ready);
endinterface

@@ src/tpe_cfg_regs.sv @@
// configuration register file
module tpe_cfg_regs
  import tpe_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  output tpe_cfg_t           cfg_o
);

  tpe_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.env_temp    <= ENV_TEMP_RST;
      cfg_q.delay_len   <= DELAY_LEN_RST;
      cfg_q.signal_gain <= SIGNAL_GAIN_RST;
      cfg_q.cool_coef   <= COOL_COEF_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENV_TEMP:    cfg_q.env_temp    <= cfg_wdata_i;
        CFG_DELAY_LEN:   cfg_q.delay_len   <= cfg_wdata_i[6:0];
        CFG_SIGNAL_GAIN: cfg_q.signal_gain <= cfg_wdata_i[15:0];
        CFG_COOL_COEF:   cfg_q.cool_coef   <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ src/tpe_rate_line.sv @@
// dead-time line memory, one write and one registered read port
module tpe_rate_line #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [AddrW-1:0]         rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [AddrW-1:0]         wr_addr_i,
  input  logic signed [31:0]       wr_data_i,
  output logic signed [31:0]       rd_data_o
);

  logic signed [31:0] mem_q [Depth];
  logic signed [31:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ src/thermal_plant_emulator.sv @@
// top level: tick sequencer and fixed-point datapath of the thermal plant emulator
// each input runs the lag, product, rate and write-back steps in order; a new drive
// is taken only when idle or when write-back finds the result register free
// the dead-time line memory is read in the product step and written back with the result
// reset: config registers take their defaults, filter and temperature state clear,
// the dead-time line holds no valid history until written; no clearing pass
`include "thermal_plant_emulator_assert.svh"

module thermal_plant_emulator
  import tpe_pkg::*;
#(
  parameter int unsigned DELAY_MAX = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  tpe_drive_if.sink          drive_i,
  tpe_result_if.source       result_o
);

  localparam int unsigned AW   = (DELAY_MAX > 1) ? $clog2(DELAY_MAX) : 1;
  localparam int unsigned FW   = $clog2(DELAY_MAX + 1);
  localparam int unsigned LENW = (FW > 7) ? FW : 7;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SMOOTH = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_RATE   = 3'd3;
  localparam logic [2:0] S_OUT    = 3'd4;

  tpe_cfg_t cfg;

  tpe_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  logic [2:0]         state_q, state_d;
  logic [31:0]        smoothed_q;
  logic signed [31:0] temp_q;
  logic signed [31:0] first_rate_q;
  logic               started_q;
  logic [AW-1:0]      wp_q;
  logic [FW-1:0]      fill_q;
  logic signed [49:0] lag_prod_q;
  logic [47:0]        term1_q;
  logic signed [49:0] term2_q;
  logic signed [31:0] rate_q;
  logic               out_valid_q;
  logic signed [31:0] out_temp_q;
  logic signed [31:0] out_rate_q;

  logic               in_xfer;
  logic               out_free;
  logic               step_out;
  logic signed [32:0] lag_diff;
  logic signed [49:0] lag_sum;
  logic [31:0]        smoothed_d;
  logic signed [32:0] cool_diff;
  logic signed [58:0] rate_sum;
  logic signed [34:0] rate_shift;
  logic [LENW-1:0]    len_ext;
  logic [LENW-1:0]    len_clamp;
  logic [AW-1:0]      lag;
  logic [AW-1:0]      rd_addr;
  logic [AW:0]        rd_addr_wrap;
  logic signed [31:0] rd_data;
  logic signed [31:0] first_eff;
  logic signed [31:0] delayed;
  logic signed [31:0] temp_next;

  assign out_free = !out_valid_q || result_o.ready;
  assign drive_i.ready = (state_q == S_IDLE) || ((state_q == S_OUT) && out_free);
  assign in_xfer  = drive_i.valid && drive_i.ready;
  assign step_out = (state_q == S_OUT) && out_free;

  // lag filter product, formed at input transfer
  assign lag_diff = $signed({1'b0, drive_i.drive, 16'h0000}) - $signed({1'b0, smoothed_q});
  assign lag_sum  = lag_prod_q + 50'sd8388608;
  assign smoothed_d = smoothed_q + {{6{lag_sum[49]}}, lag_sum[49:24]};

  assign cool_diff = $signed({cfg.env_temp[31], cfg.env_temp}) - $signed({temp_q[31], temp_q});

  assign rate_sum = $signed({11'h000, term1_q})
                  + $signed({term2_q[49], term2_q, 8'h00})
                  + 59'sd8388608;
  assign rate_shift = rate_sum[58:24];

  // dead-time length clamp and read address
  always_comb begin
    len_ext = LENW'(cfg.delay_len);
    if (len_ext == '0) begin
      len_clamp = LENW'(1);
    end else if (len_ext > LENW'(DELAY_MAX)) begin
      len_clamp = LENW'(DELAY_MAX);
    end else begin
      len_clamp = len_ext;
    end
  end

  assign lag = AW'(len_clamp - LENW'(1));

  always_comb begin
    rd_addr_wrap = {1'b0, wp_q} + (AW + 1)'(DELAY_MAX) - {1'b0, lag};
    if (wp_q >= lag) begin
      rd_addr = wp_q - lag;
    end else begin
      rd_addr = rd_addr_wrap[AW-1:0];
    end
  end

  tpe_rate_line #(
    .Depth (DELAY_MAX),
    .AddrW (AW)
  ) u_line (
    .clk_i     (clk_i),
    .rd_en_i   (state_q == S_MUL),
    .rd_addr_i (rd_addr),
    .wr_en_i   (step_out),
    .wr_addr_i (wp_q),
    .wr_data_i (rate_q),
    .rd_data_o (rd_data)
  );

  assign first_eff = started_q ? first_rate_q : rate_q;

  always_comb begin
    if (lag == '0) begin
      delayed = rate_q;
    end else if (fill_q >= FW'(lag)) begin
      delayed = rd_data;
    end else begin
      delayed = first_eff;
    end
  end

  assign temp_next = sat32(35'(temp_q) + 35'(delayed));

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_xfer) state_d = S_SMOOTH;
      S_SMOOTH: state_d = S_MUL;
      S_MUL:    state_d = S_RATE;
      S_RATE:   state_d = S_OUT;
      S_OUT: begin
        if (out_free) begin
          state_d = in_xfer ? S_SMOOTH : S_IDLE;
        end
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      smoothed_q   <= '0;
      temp_q       <= '0;
      first_rate_q <= '0;
      started_q    <= 1'b0;
      wp_q         <= '0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_SMOOTH) begin
        smoothed_q <= smoothed_d;
        if (!started_q) begin
          temp_q <= cfg.env_temp;
        end
      end
      if (step_out) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (step_out) begin
        temp_q      <= temp_next;
        started_q   <= 1'b1;
        if (!started_q) begin
          first_rate_q <= rate_q;
        end
        wp_q <= (wp_q == AW'(DELAY_MAX - 1)) ? '0 : wp_q + AW'(1);
        if (fill_q < FW'(DELAY_MAX)) begin
          fill_q <= fill_q + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      lag_prod_q <= lag_diff * $signed({1'b0, LAG_GAIN});
    end
    if (state_q == S_MUL) begin
      term1_q <= smoothed_q * cfg.signal_gain;
      term2_q <= cool_diff * $signed({1'b0, cfg.cool_coef});
    end
    if (state_q == S_RATE) begin
      rate_q <= sat32(rate_shift);
    end
    if (step_out) begin
      out_temp_q <= temp_next;
      out_rate_q <= rate_q;
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.temperature = out_temp_q;
  assign result_o.heat_rate   = out_rate_q;

  `TPE_ASSERT(a_fill_bound, fill_q <= FW'(DELAY_MAX))
  `TPE_ASSERT(a_wp_bound, wp_q <= AW'(DELAY_MAX - 1))
  `TPE_ASSERT(a_result_from_out, $rose(out_valid_q) |-> $past(state_q) == S_OUT)
  `TPE_ASSERT(a_read_not_write, (state_q == S_MUL && lag != '0) |-> rd_addr != wp_q)

endmodule

@@ test/tb.sv @@
// testbench for the thermal plant emulator: random drive transfers checked against a plant predictor
module tb;
  import tpe_pkg::*;

  localparam longint LAG_Q24     = 64'sd50332;
  localparam longint HALF_LSB    = 64'sd8388608;
  localparam int     LINE_DEPTH  = 64;
  localparam int     CYCLE_LIMIT = 200000;
  localparam int     TAIL_CYCLES = 20;

  typedef struct {
    logic signed [31:0] temperature;
    logic signed [31:0] heat_rate;
  } plant_out_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [31:0]        cfg_wdata_i;

  tpe_drive_if  drv_if ();
  tpe_result_if res_if ();

  thermal_plant_emulator u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .drive_i     (drv_if),
    .result_o    (res_if)
  );

  // predictor copy of the registers
  logic signed [31:0] amb_temp;
  logic [6:0]         dead_len;
  logic [15:0]        drive_gain;
  logic [15:0]        loss_gain;

  // predictor copy of the plant state
  logic [31:0]        sm_drive;
  logic signed [31:0] cur_temp;
  logic               running;
  logic signed [31:0] seed_rate;
  logic signed [31:0] rate_hist [LINE_DEPTH];
  logic [5:0]         hist_wr;
  logic [6:0]         hist_fill;

  logic [15:0] drive_backlog [$];
  plant_out_t  expected_readings [$];

  logic drive_taken;
  int   drv_gap;
  int   rsp_stall;
  int   drv_idle_max;
  int   rsp_idle_max;
  int   ticks_sent;
  int   readings_checked;
  int   fault_count;
  int   setting_count;
  int   cycle_count;

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic plant_out_t plant_tick(input logic [15:0] drive);
    plant_out_t         r;
    longint             err;
    longint             step;
    longint             heat;
    longint             cool;
    logic [6:0]         len;
    logic [5:0]         lag;
    logic signed [31:0] rate;
    logic signed [31:0] delayed;
    err = longint'({drive, 16'h0000}) - longint'(sm_drive);
    step = (err * LAG_Q24 + HALF_LSB) >>> 24;
    sm_drive = sm_drive + step[31:0];
    if (!running) cur_temp = amb_temp;
    heat = longint'(sm_drive) * longint'(drive_gain);
    cool = (longint'(amb_temp) - longint'(cur_temp)) * longint'(loss_gain) * 256;
    rate = clamp32((heat + cool + HALF_LSB) >>> 24);
    if (!running) begin
      running = 1'b1;
      seed_rate = rate;
    end
    if (dead_len == 7'd0) len = 7'd1;
    else if (dead_len > 7'd64) len = 7'd64;
    else len = dead_len;
    lag = 6'(len - 7'd1);
    if (lag == 6'd0) delayed = rate;
    else if (hist_fill >= {1'b0, lag}) delayed = rate_hist[6'(hist_wr - lag)];
    else delayed = seed_rate;
    rate_hist[hist_wr] = rate;
    hist_wr = hist_wr + 6'd1;
    if (hist_fill < 7'd64) hist_fill = hist_fill + 7'd1;
    cur_temp = clamp32(longint'(cur_temp) + longint'(delayed));
    r.temperature = cur_temp;
    r.heat_rate = rate;
    return r;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // transfer bookkeeping, prediction and checking
  always @(posedge clk_i) begin
    plant_out_t want;
    drive_taken = 1'b0;
    if (rst_ni) begin
      if (drv_if.valid && drv_if.ready) begin
        drive_taken = 1'b1;
        expected_readings.push_back(plant_tick(drv_if.drive));
        ticks_sent++;
      end
      if (res_if.valid && res_if.ready) begin
        rsp_stall = $urandom_range(0, rsp_idle_max);
        if (expected_readings.size() == 0) begin
          $display("%0t: unexpected reading, temperature %0d heat_rate %0d", $time,
                   res_if.temperature, res_if.heat_rate);
          fault_count++;
        end else begin
          want = expected_readings.pop_front();
          readings_checked++;
          if (res_if.temperature !== want.temperature) begin
            $display("%0t: temperature mismatch, expected %0d, actual %0d", $time,
                     want.temperature, res_if.temperature);
            fault_count++;
          end
          if (res_if.heat_rate !== want.heat_rate) begin
            $display("%0t: heat_rate mismatch, expected %0d, actual %0d", $time,
                     want.heat_rate, res_if.heat_rate);
            fault_count++;
          end
        end
      end
    end
  end

  // drive side
  always @(negedge clk_i) begin
    logic        nxt_valid;
    logic [15:0] nxt_drive;
    if (rst_ni) begin
      nxt_valid = drv_if.valid;
      nxt_drive = drv_if.drive;
      if (drv_if.valid && drive_taken) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (drv_gap > 0) begin
          drv_gap--;
        end else if (drive_backlog.size() != 0) begin
          nxt_drive = drive_backlog.pop_front();
          nxt_valid = 1'b1;
          drv_gap = $urandom_range(0, drv_idle_max);
        end
      end
      drv_if.valid <= nxt_valid;
      drv_if.drive <= nxt_drive;
    end
  end

  // result side
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_stall > 0) begin
        rsp_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d readings outstanding", $time, expected_readings.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic set_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ENV_TEMP:    amb_temp = val;
      CFG_DELAY_LEN:   dead_len = val[6:0];
      CFG_SIGNAL_GAIN: drive_gain = val[15:0];
      CFG_COOL_COEF:   loss_gain = val[15:0];
      default: ;
    endcase
  endtask

  task automatic program_plant(input logic [31:0] env, input logic [6:0] dlen,
                               input logic [15:0] sg, input logic [15:0] cc);
    set_reg(CFG_ENV_TEMP, env);
    set_reg(CFG_DELAY_LEN, {25'($urandom), dlen});
    set_reg(CFG_SIGNAL_GAIN, {16'($urandom), sg});
    set_reg(CFG_COOL_COEF, {16'($urandom), cc});
    setting_count++;
  endtask

  task automatic settle();
    while (drive_backlog.size() != 0 || drv_if.valid || expected_readings.size() != 0)
      @(posedge clk_i);
  endtask

  // held drive levels with occasional one-tick spikes
  task automatic queue_drives(input int n);
    logic [15:0] level;
    int          hold;
    hold = 0;
    level = '0;
    repeat (n) begin
      if (hold == 0) begin
        case ($urandom_range(0, 4))
          0: level = 16'h0000;
          1: level = 16'hffff;
          default: level = 16'($urandom_range(0, 65535));
        endcase
        hold = $urandom_range(1, 12);
      end
      if ($urandom_range(0, 5) == 0) drive_backlog.push_back(16'($urandom_range(0, 65535)));
      else drive_backlog.push_back(level);
      hold--;
    end
  endtask

  initial begin
    logic [31:0] env;
    logic [6:0]  dlen;
    logic [15:0] sg;
    logic [15:0] cc;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    drv_if.valid = 1'b0;
    drv_if.drive = '0;
    res_if.ready = 1'b0;
    amb_temp     = ENV_TEMP_RST;
    dead_len     = DELAY_LEN_RST;
    drive_gain   = SIGNAL_GAIN_RST;
    loss_gain    = COOL_COEF_RST;
    sm_drive     = '0;
    cur_temp     = '0;
    running      = 1'b0;
    seed_rate    = '0;
    hist_wr      = '0;
    hist_fill    = '0;
    drive_taken  = 1'b0;
    drv_gap      = 0;
    rsp_stall    = 0;
    drv_idle_max = 6;
    rsp_idle_max = 6;
    ticks_sent   = 0;
    readings_checked = 0;
    fault_count  = 0;
    setting_count = 1;
    cycle_count  = 0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // first tick and the unfilled line at reset settings
    drive_backlog = '{16'h0000, 16'h0000, 16'hffff, 16'hffff, 16'h0001, 16'h8000,
                      16'h5555, 16'haaaa, 16'h7fff, 16'h0100, 16'hffff, 16'hffff};
    settle();
    // no delay, zero length, overlong length, then a short lag mid-run
    set_reg(CFG_DELAY_LEN, 32'd1);
    drive_backlog = '{16'hffff, 16'hffff, 16'hffff};
    settle();
    set_reg(CFG_DELAY_LEN, 32'd0);
    drive_backlog = '{16'h0000, 16'hffff, 16'h1234};
    settle();
    set_reg(CFG_DELAY_LEN, 32'd127);
    drive_backlog = '{16'hffff, 16'h00ff, 16'hff00};
    settle();
    set_reg(CFG_DELAY_LEN, 32'd2);
    drive_backlog = '{16'h8001, 16'hfffe, 16'h0000};
    settle();
    setting_count += 4;

    // saturation toward both rails
    program_plant(32'h7fffffff, 7'd1, 16'hffff, 16'hffff);
    repeat (10) drive_backlog.push_back(16'hffff);
    settle();
    program_plant(32'h80000000, 7'd64, 16'h0000, 16'hffff);
    queue_drives(40);
    settle();
    program_plant(32'h00000000, 7'd65, 16'hffff, 16'h0000);
    queue_drives(20);
    settle();

    repeat (12) begin
      case ($urandom_range(0, 5))
        0: env = 32'h7fffffff;
        1: env = 32'h80000000;
        2: env = 32'h00000000;
        3: env = $urandom();
        default: env = $urandom_range(0, 200 << 16) - (100 << 16);
      endcase
      case ($urandom_range(0, 5))
        0: dlen = 7'd0;
        1: dlen = 7'd64;
        2: dlen = 7'($urandom_range(65, 127));
        default: dlen = 7'($urandom_range(1, 64));
      endcase
      case ($urandom_range(0, 3))
        0: sg = 16'h0000;
        1: sg = 16'hffff;
        default: sg = 16'($urandom_range(0, 65535));
      endcase
      case ($urandom_range(0, 3))
        0: cc = 16'h0000;
        1: cc = 16'hffff;
        default: cc = 16'($urandom_range(0, 4000));
      endcase
      drv_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      rsp_idle_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      program_plant(env, dlen, sg, cc);
      queue_drives(36);
      settle();
    end

    drv_idle_max = 6;
    rsp_idle_max = 6;
    program_plant(ENV_TEMP_RST, DELAY_LEN_RST, SIGNAL_GAIN_RST, COOL_COEF_RST);
    queue_drives(20);
    settle();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d drive transfers under %0d register settings, rails and dead-time extremes",
             ticks_sent, setting_count);
    $display("%0d readings checked, %0d mismatches", readings_checked, fault_count);
    if (fault_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
